/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent assertions of the converter checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while reset is held.
`define KVJ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that is also checked while reset is held.
`define KVJ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/kvj_pkg.sv */
// ----------------------------------------------------------------------------
// KeyValues to JSON package
// Character codes, parser phases, status codes and the result types.
// ----------------------------------------------------------------------------
`default_nettype none

package kvj_pkg;

  // Width of the reported error position.
  localparam int unsigned ERR_POS_BITS = 24;

  // Characters that the parser looks for or emits.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // Parser phases.
  localparam logic [2:0] PH_OUT  = 3'd0;
  localparam logic [2:0] PH_OBJ  = 3'd1;
  localparam logic [2:0] PH_KEY0 = 3'd2;
  localparam logic [2:0] PH_KEY  = 3'd3;
  localparam logic [2:0] PH_BETW = 3'd4;
  localparam logic [2:0] PH_VAL0 = 3'd5;
  localparam logic [2:0] PH_VAL  = 3'd6;

  // Status codes of a result word.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_OPEN  = 3'd1;
  localparam logic [2:0] ST_BAD_OBJ   = 3'd2;
  localparam logic [2:0] ST_BAD_VAL   = 3'd3;
  localparam logic [2:0] ST_END_OBJ   = 3'd4;
  localparam logic [2:0] ST_END_KEY   = 3'd5;
  localparam logic [2:0] ST_END_BETW  = 3'd6;
  localparam logic [2:0] ST_END_VAL   = 3'd7;

  // One result word.
  typedef struct packed {
    logic [7:0]              out_byte;
    logic [2:0]              status;
    logic [ERR_POS_BITS-1:0] error_position;
    logic                    final_res;
  } result_t;

  // Up to two result words caused by one input word.
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } res_pair_t;

  function automatic result_t mk_res(input logic [7:0] b, input logic [2:0] st,
                                     input logic [ERR_POS_BITS-1:0] pos,
                                     input logic fin);
    result_t r;
    r.out_byte       = b;
    r.status         = st;
    r.error_position = pos;
    r.final_res      = fin;
    return r;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/kvj_if.sv */
// ----------------------------------------------------------------------------
// KeyValues to JSON channels
// Valid/ready channels for the input words and the result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface kvj_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] in_byte;

  modport source (output valid, output op, output in_byte, input ready);
  modport sink   (input valid, input op, input in_byte, output ready);
endinterface

interface kvj_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [2:0]  status;
  logic [23:0] error_position;
  logic        final_res;

  modport source (output valid, output out_byte, output status,
                  output error_position, output final_res, input ready);
  modport sink   (input valid, input out_byte, input status,
                  input error_position, input final_res, output ready);
endinterface

`default_nettype wire

/* hw/rtl/keyvalues_to_json_converter_top.sv */
// ----------------------------------------------------------------------------
// KeyValues to JSON converter
// Streams KeyValues objects in and a JSON array of objects out, one
// character per result word.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Payload                                       | Handshake
//  in_word  | sink      | op, in_byte                                   | valid/ready
//  out_word | source    | out_byte, status, error_position, final_res   | valid/ready
//
// An input word causes zero, one or two result words, computed in the cycle
// it is accepted and held in a two-entry pending register.
// Result words leave through a registered output at one per cycle while the
// sink is ready. A new word is taken as soon as the pending register will be
// empty, even while the output register waits on a stalled sink.
// Reset is synchronous and clears the parser state and all valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module keyvalues_to_json_converter_top #(
  parameter int unsigned POSITION_BITS = 24
) (
  input wire logic  clk,
  input wire logic  rst_n,
  kvj_in_if.sink    in_word,
  kvj_out_if.source out_word
);

  logic               in_accept;
  logic               out_load;
  logic               in_ready;
  kvj_pkg::res_pair_t new_pair;
  kvj_pkg::res_pair_t pend_r, pend_nxt;
  kvj_pkg::result_t   out_res_r;
  logic               out_valid_r;

  // Parser with the converter state.
  kvj_parser #(
    .POSITION_BITS (POSITION_BITS)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_accept),
    .op      (in_word.op),
    .in_byte (in_word.in_byte),
    .pair    (new_pair)
  );

  // Handshake decisions.
  assign out_load  = (pend_r.cnt != 2'd0) && (!out_valid_r || out_word.ready);
  assign in_ready  = (pend_r.cnt == 2'd0) || ((pend_r.cnt == 2'd1) && out_load);
  assign in_accept = in_word.valid && in_ready;

  // Pending results: refilled by a new word, otherwise shifted on a load.
  always_comb begin
    pend_nxt = pend_r;
    if (in_accept) begin
      pend_nxt = new_pair;
    end else if (out_load) begin
      pend_nxt.r0  = pend_r.r1;
      pend_nxt.cnt = pend_r.cnt - 2'd1;
    end
  end

  // Only the count needs a reset; the held results are qualified by it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r.cnt <= 2'd0;
    end else begin
      pend_r.cnt <= pend_nxt.cnt;
    end
    pend_r.r0 <= pend_nxt.r0;
    pend_r.r1 <= pend_nxt.r1;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_word.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res_r <= pend_r.r0;
    end
  end

  assign in_word.ready           = in_ready;
  assign out_word.valid          = out_valid_r;
  assign out_word.out_byte       = out_res_r.out_byte;
  assign out_word.status         = out_res_r.status;
  assign out_word.error_position = out_res_r.error_position;
  assign out_word.final_res      = out_res_r.final_res;

endmodule

`default_nettype wire

/* hw/rtl/kvj_parser.sv */
// ----------------------------------------------------------------------------
// KeyValues to JSON parser
// Holds the parser state and works out the result words of one input word.
// ----------------------------------------------------------------------------
`default_nettype none

module kvj_parser #(
  parameter int unsigned POSITION_BITS = 24
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 accept,
  input  wire logic                 op,
  input  wire logic [7:0]           in_byte,
  output kvj_pkg::res_pair_t        pair
);

  logic [2:0]               phase_r, phase_nxt;
  logic                     started_r, started_nxt;
  logic                     object_made_r, object_made_nxt;
  logic                     pair_made_r, pair_made_nxt;
  logic                     prev_bs_r, prev_bs_nxt;
  logic                     ended_r, ended_nxt;
  logic [2:0]               err_code_r, err_code_nxt;
  logic [POSITION_BITS-1:0] byte_pos_r, byte_pos_nxt;
  logic [POSITION_BITS-1:0] err_idx_r, err_idx_nxt;

  logic [POSITION_BITS-1:0] pos_inc;
  logic                     str_close;
  logic                     advance;
  logic [1:0]               nb;
  kvj_pkg::result_t         e0, e1, lead_res;

  // Saturating increment of the character index.
  assign pos_inc   = (&byte_pos_r) ? byte_pos_r : byte_pos_r + POSITION_BITS'(1);
  assign str_close = (in_byte == kvj_pkg::CH_QUOTE) && !prev_bs_r;
  assign lead_res  = kvj_pkg::mk_res(kvj_pkg::CH_LBRACK, kvj_pkg::ST_OK, '0, 1'b0);

  // Next state and the body results of the word on the input.
  always_comb begin
    phase_nxt       = phase_r;
    started_nxt     = 1'b1;
    object_made_nxt = object_made_r;
    pair_made_nxt   = pair_made_r;
    prev_bs_nxt     = prev_bs_r;
    ended_nxt       = ended_r;
    err_code_nxt    = err_code_r;
    err_idx_nxt     = err_idx_r;
    byte_pos_nxt    = byte_pos_r;
    advance         = 1'b0;
    nb              = 2'd0;
    e0              = kvj_pkg::mk_res(in_byte, kvj_pkg::ST_OK, '0, 1'b0);
    e1              = kvj_pkg::mk_res(in_byte, kvj_pkg::ST_OK, '0, 1'b0);

    if (op) begin
      // End of input: close the array or report the error.
      ended_nxt = 1'b1;
      if (err_code_r == kvj_pkg::ST_OK) begin
        case (phase_r)
          kvj_pkg::PH_OBJ: begin
            err_code_nxt = kvj_pkg::ST_END_OBJ;
            err_idx_nxt  = byte_pos_r;
          end
          kvj_pkg::PH_KEY0, kvj_pkg::PH_KEY: begin
            err_code_nxt = kvj_pkg::ST_END_KEY;
            err_idx_nxt  = byte_pos_r;
          end
          kvj_pkg::PH_BETW: begin
            err_code_nxt = kvj_pkg::ST_END_BETW;
            err_idx_nxt  = byte_pos_r;
          end
          kvj_pkg::PH_VAL0, kvj_pkg::PH_VAL: begin
            err_code_nxt = kvj_pkg::ST_END_VAL;
            err_idx_nxt  = byte_pos_r;
          end
          default: begin
          end
        endcase
      end
      nb = 2'd1;
      if (err_code_nxt == kvj_pkg::ST_OK) begin
        e0 = kvj_pkg::mk_res(kvj_pkg::CH_RBRACK, kvj_pkg::ST_OK, '0, 1'b1);
      end else begin
        e0 = kvj_pkg::mk_res(kvj_pkg::CH_NUL, err_code_nxt,
                             kvj_pkg::ERR_POS_BITS'(err_idx_nxt), 1'b1);
      end
    end else if (!ended_r && (err_code_r == kvj_pkg::ST_OK)) begin
      case (phase_r)
        kvj_pkg::PH_OBJ: begin
          if (in_byte == kvj_pkg::CH_NUL) begin
            ended_nxt = 1'b1;
          end else if (kvj_pkg::is_space(in_byte)) begin
            nb      = 2'd1;
            advance = 1'b1;
          end else if (in_byte == kvj_pkg::CH_QUOTE) begin
            // A comma goes before every pair but the first.
            if (pair_made_r) begin
              nb = 2'd2;
              e0 = kvj_pkg::mk_res(kvj_pkg::CH_COMMA, kvj_pkg::ST_OK, '0, 1'b0);
            end else begin
              nb = 2'd1;
            end
            phase_nxt = kvj_pkg::PH_KEY0;
            advance   = 1'b1;
          end else if (in_byte == kvj_pkg::CH_RBRACE) begin
            nb              = 2'd1;
            object_made_nxt = 1'b1;
            pair_made_nxt   = 1'b0;
            phase_nxt       = kvj_pkg::PH_OUT;
            advance         = 1'b1;
          end else begin
            err_code_nxt = kvj_pkg::ST_BAD_OBJ;
            err_idx_nxt  = byte_pos_r;
          end
        end
        kvj_pkg::PH_KEY0, kvj_pkg::PH_KEY: begin
          if ((phase_r == kvj_pkg::PH_KEY0) && (in_byte == kvj_pkg::CH_NUL)) begin
            ended_nxt = 1'b1;
          end else begin
            nb        = 2'd1;
            phase_nxt = str_close ? kvj_pkg::PH_BETW : kvj_pkg::PH_KEY;
            advance   = 1'b1;
          end
        end
        kvj_pkg::PH_BETW: begin
          if (in_byte == kvj_pkg::CH_NUL) begin
            ended_nxt = 1'b1;
          end else if (kvj_pkg::is_space(in_byte)) begin
            nb      = 2'd1;
            advance = 1'b1;
          end else if (in_byte == kvj_pkg::CH_QUOTE) begin
            nb        = 2'd2;
            e0        = kvj_pkg::mk_res(kvj_pkg::CH_COLON, kvj_pkg::ST_OK, '0, 1'b0);
            phase_nxt = kvj_pkg::PH_VAL0;
            advance   = 1'b1;
          end else begin
            err_code_nxt = kvj_pkg::ST_BAD_VAL;
            err_idx_nxt  = pos_inc;
          end
        end
        kvj_pkg::PH_VAL0, kvj_pkg::PH_VAL: begin
          if ((phase_r == kvj_pkg::PH_VAL0) && (in_byte == kvj_pkg::CH_NUL)) begin
            ended_nxt = 1'b1;
          end else begin
            nb      = 2'd1;
            advance = 1'b1;
            if (str_close) begin
              pair_made_nxt = 1'b1;
              phase_nxt     = kvj_pkg::PH_OBJ;
            end else begin
              phase_nxt = kvj_pkg::PH_VAL;
            end
          end
        end
        default: begin
          if (in_byte == kvj_pkg::CH_NUL) begin
            ended_nxt = 1'b1;
          end else if (kvj_pkg::is_space(in_byte)) begin
            nb      = 2'd1;
            advance = 1'b1;
          end else if (in_byte == kvj_pkg::CH_LBRACE) begin
            // A comma goes before every object but the first.
            if (object_made_r) begin
              nb = 2'd2;
              e0 = kvj_pkg::mk_res(kvj_pkg::CH_COMMA, kvj_pkg::ST_OK, '0, 1'b0);
            end else begin
              nb = 2'd1;
            end
            phase_nxt = kvj_pkg::PH_OBJ;
            advance   = 1'b1;
          end else begin
            err_code_nxt = kvj_pkg::ST_BAD_OPEN;
            err_idx_nxt  = pos_inc;
          end
        end
      endcase
    end

    // A consumed character moves the index and the escape flag.
    if (advance) begin
      prev_bs_nxt  = (in_byte == kvj_pkg::CH_BSLASH);
      byte_pos_nxt = pos_inc;
    end
  end

  // Put the opening bracket of the first word in front of the body results.
  always_comb begin
    if (!started_r) begin
      pair.r0  = lead_res;
      pair.r1  = e0;
      pair.cnt = nb + 2'd1;
    end else begin
      pair.r0  = e0;
      pair.r1  = e1;
      pair.cnt = nb;
    end
  end

  // State registers, loaded on every accepted word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= kvj_pkg::PH_OUT;
      started_r     <= 1'b0;
      object_made_r <= 1'b0;
      pair_made_r   <= 1'b0;
      prev_bs_r     <= 1'b0;
      ended_r       <= 1'b0;
      err_code_r    <= kvj_pkg::ST_OK;
      byte_pos_r    <= '0;
      err_idx_r     <= '0;
    end else if (accept) begin
      phase_r       <= phase_nxt;
      started_r     <= started_nxt;
      object_made_r <= object_made_nxt;
      pair_made_r   <= pair_made_nxt;
      prev_bs_r     <= prev_bs_nxt;
      ended_r       <= ended_nxt;
      err_code_r    <= err_code_nxt;
      byte_pos_r    <= byte_pos_nxt;
      err_idx_r     <= err_idx_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/kvj_checker.sv */
// ----------------------------------------------------------------------------
// KeyValues to JSON checker
// Port-level assertions on the result channel of the converter.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module kvj_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [7:0]  out_byte,
  input wire logic [2:0]  status,
  input wire logic [23:0] error_position,
  input wire logic        final_res
);

  // A stalled word stays offered.
  `KVJ_ASSERT(a_hold_valid, clk, rst_n, out_valid && !out_ready |=> out_valid, "word dropped")

  // A stalled word keeps its payload.
  `KVJ_ASSERT(a_hold_data, clk, rst_n, out_valid && !out_ready |=> $stable(out_byte) && $stable(status) && $stable(error_position) && $stable(final_res), "payload changed")

  // Reset empties the output.
  `KVJ_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "valid after reset")

  // A good character carries no error position.
  `KVJ_ASSERT(a_ok_no_pos, clk, rst_n, out_valid && (status == 3'd0) |-> (error_position == 24'd0), "position on good word")

  // An error is only ever the final answer and carries no character.
  `KVJ_ASSERT(a_err_final, clk, rst_n, out_valid && (status != 3'd0) |-> final_res && (out_byte == 8'd0), "error word not final")

endmodule

bind keyvalues_to_json_converter_top kvj_checker u_kvj_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_word.valid),
  .out_ready      (out_word.ready),
  .out_byte       (out_word.out_byte),
  .status         (out_word.status),
  .error_position (out_word.error_position),
  .final_res      (out_word.final_res)
);

`default_nettype wire
